>>> design/sorted_array_table_top_defines.svh
// Assertion macros for the sorted array table.
`ifndef SORTED_ARRAY_TABLE_TOP_DEFINES_SVH
`define SORTED_ARRAY_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAT_ASSERT(lbl, prop, msg)
`define SAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/sat_pkg.sv
// Shared types and constants for the sorted array table.
package sat_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int CAP_W  = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RM_RD,
    ST_RM_WR,
    ST_LK_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> design/sat_store.sv
// Key store: one write port and one registered read port.
module sat_store
  import sat_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         mem_req,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata <= mem[mem_req.raddr];
  end

endmodule

>>> design/sat_ctrl.sv
// Request sequencer: one compare unit and a shift pass over the store.
module sat_ctrl
  import sat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  logic [KEY_W-1:0]  key,
  input  logic [ADDR_W-1:0] position,
  input  logic [CNT_W-1:0]  limit,
  input  logic [KEY_W-1:0]  mem_rdata,
  output mem_req_t          mem_req,
  output logic              busy,
  output logic              done,
  output logic [KEY_W-1:0]  read_key,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  entry_count
);

  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  logic [KEY_W-1:0] key_reg, key_reg_next;
  logic             done_next;
  logic [KEY_W-1:0] read_key_next;
  logic [1:0]       status_next;
  logic [CNT_W-1:0] idx_dec, idx_inc;
  logic             key_not_smaller;

  assign idx_dec = idx - CNT_W'(1);
  assign idx_inc = idx + CNT_W'(1);
  // The single comparator: does the stored key sit at or above the new key?
  assign key_not_smaller = (mem_rdata >= key_reg);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_INSERT: if (count < limit) state_next = ST_INS_RD;
            REQ_LOOKUP: if (CNT_W'(position) < count) state_next = ST_LK_DONE;
            REQ_REMOVE: if (CNT_W'(position) < count) state_next = ST_RM_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD:  state_next = (idx == '0) ? ST_IDLE : ST_INS_CMP;
      ST_INS_CMP: state_next = key_not_smaller ? ST_INS_RD : ST_IDLE;
      ST_RM_RD:   state_next = (idx_inc >= count) ? ST_IDLE : ST_RM_WR;
      ST_RM_WR:   state_next = ST_RM_RD;
      ST_LK_DONE: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_next      = idx;
    count_next    = count;
    key_reg_next  = key_reg;
    done_next     = 1'b0;
    read_key_next = '0;
    status_next   = STATUS_OK;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx[ADDR_W-1:0];
    mem_req.wdata = key_reg;
    mem_req.raddr = position;
    case (state)
      ST_IDLE: begin
        if (start) begin
          key_reg_next = key;
          case (req_type)
            REQ_INSERT: begin
              if (count < limit) begin
                idx_next = count;
              end else begin
                done_next   = 1'b1;
                status_next = STATUS_FULL;
              end
            end
            REQ_LOOKUP: begin
              // The read of the requested entry is already under way.
              if (CNT_W'(position) >= count) begin
                done_next   = 1'b1;
                status_next = STATUS_RANGE;
              end
            end
            REQ_REMOVE: begin
              if (CNT_W'(position) < count) begin
                idx_next = CNT_W'(position);
              end else begin
                done_next   = 1'b1;
                status_next = STATUS_RANGE;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ST_INS_RD: begin
        mem_req.raddr = idx_dec[ADDR_W-1:0];
        if (idx == '0) begin
          mem_req.we = 1'b1;
          count_next = count + CNT_W'(1);
          done_next  = 1'b1;
        end
      end
      ST_INS_CMP: begin
        mem_req.we = 1'b1;
        if (key_not_smaller) begin
          mem_req.wdata = mem_rdata;
          idx_next      = idx_dec;
        end else begin
          count_next = count + CNT_W'(1);
          done_next  = 1'b1;
        end
      end
      ST_RM_RD: begin
        mem_req.raddr = idx_inc[ADDR_W-1:0];
        if (idx_inc >= count) begin
          count_next = count - CNT_W'(1);
          done_next  = 1'b1;
        end
      end
      ST_RM_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        idx_next      = idx_inc;
      end
      ST_LK_DONE: begin
        done_next     = 1'b1;
        read_key_next = mem_rdata;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    key_reg     <= key_reg_next;
    read_key    <= read_key_next;
    status      <= status_next;
    entry_count <= count_next;
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> design/sorted_array_table_top.sv
// Top level of the sorted array table: capacity register, sequencer and store.
//
// Keeps up to sixteen 32-bit keys in ascending unsigned order. A request is
// taken when start is high and busy is low; req_type selects insert, lookup
// by position or remove by position. Each request gives one result on
// read_key, status and entry_count, marked by done for a single cycle; the
// receiver cannot hold it off, so it must take it in that cycle.
// A full table, an out-of-range position or an unused request type is
// answered straight from idle; a lookup takes the key read at acceptance;
// a remove or an insert shifts entries through the store's single registered
// read port, so each entry moved costs one read and one write.
// busy is high while the sequencer steps through a request and drops in the
// cycle that done is shown, so the next request may be taken then; requests
// answered straight from idle never raise busy.
// The capacity register is written through cfg_valid / capacity; cfg_ready
// is always high. Writes are to be made only while no request is in flight:
// the user must keep to this, as the block itself does not enforce it.
// Reset empties the table and sets the capacity to sixteen; the store
// contents are left as they are and only entries below the count are read.
`include "sorted_array_table_top_defines.svh"

module sorted_array_table_top
  import sat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [KEY_W-1:0]  key,
  input  logic [ADDR_W-1:0] position,
  output logic              done,
  output logic [KEY_W-1:0]  read_key,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  entry_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  capacity
);

  logic [CAP_W-1:0] table_capacity;
  logic [CNT_W-1:0] limit;
  mem_req_t         mem_req;
  logic [KEY_W-1:0] mem_rdata;
  logic             full_reported;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_capacity <= CAP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      table_capacity <= capacity;
    end
  end

  // The limit in force is the smaller of the capacity and the store depth.
  assign limit = (32'(table_capacity) < DEPTH) ? CNT_W'(table_capacity) : CNT_W'(DEPTH);

  sat_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !busy),
    .req_type    (req_type),
    .key         (key),
    .position    (position),
    .limit       (limit),
    .mem_rdata   (mem_rdata),
    .mem_req     (mem_req),
    .busy        (busy),
    .done        (done),
    .read_key    (read_key),
    .status      (status),
    .entry_count (entry_count)
  );

  sat_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  assign full_reported = done && (status == STATUS_FULL);

  `SAT_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "request lost")
  `SAT_ASSERT_ALWAYS(a_done_idle, done |-> !busy, "result shown while busy")
  `SAT_ASSERT(a_count_bound, done |-> (32'(entry_count) <= DEPTH), "count beyond depth")
  `SAT_ASSERT(a_full_no_change, full_reported |-> (entry_count >= limit), "full below limit")

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the sorted array table: random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import sat_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;

  typedef struct {
    logic [1:0]        req;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] pos;
  } request_t;

  typedef struct {
    logic [KEY_W-1:0] read_key;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } table_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} req_mix_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        req_type = REQ_INSERT;
  logic [KEY_W-1:0]  key = '0;
  logic [ADDR_W-1:0] position = '0;
  logic              done;
  logic [KEY_W-1:0]  read_key;
  logic [1:0]        status;
  logic [CNT_W-1:0]  entry_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  capacity = CAP_W'(16);

  request_t      queued_requests[$];
  table_result_t predicted_results[$];
  request_t      offered;
  bit            holding = 1'b0;
  int            gap_left = 0;
  bit            quiet = 1'b0;
  int            error_count = 0;
  int            cycle_count = 0;

  // Predictor state: the ordered keys, their count and the capacity in force.
  logic [KEY_W-1:0] table_keys[DEPTH];
  int               table_count = 0;
  int               table_cap = 16;

  sorted_array_table_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .key(key), .position(position),
    .done(done), .read_key(read_key), .status(status), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity)
  );

  always #5 clk = ~clk;

  function automatic table_result_t table_apply(request_t r);
    table_result_t res;
    int limit;
    int slot;
    int i;
    limit = (table_cap < DEPTH) ? table_cap : DEPTH;
    res.read_key = '0;
    res.status = STATUS_OK;
    case (r.req)
      REQ_INSERT: begin
        if (table_count >= limit) begin
          res.status = STATUS_FULL;
        end else begin
          slot = 0;
          while (slot < table_count && table_keys[slot] < r.key) slot++;
          for (i = table_count; i > slot; i--) table_keys[i] = table_keys[i-1];
          table_keys[slot] = r.key;
          table_count++;
        end
      end
      REQ_LOOKUP: begin
        if (int'(r.pos) >= table_count) res.status = STATUS_RANGE;
        else res.read_key = table_keys[r.pos];
      end
      REQ_REMOVE: begin
        if (int'(r.pos) >= table_count) begin
          res.status = STATUS_RANGE;
        end else begin
          for (i = int'(r.pos); i + 1 < table_count; i++) table_keys[i] = table_keys[i+1];
          table_count--;
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(table_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: holds a request until it is taken, then predicts its result.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(table_apply(offered));
        holding = 1'b0;
      end
      if (start && busy) begin
        // Request still waiting; keep it on the ports.
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_requests.size() != 0) begin
        offered = queued_requests.pop_front();
        holding = 1'b1;
        req_type <= offered.req;
        key <= offered.key;
        position <= offered.pos;
        start <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result is taken in its single strobe cycle.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", read_key, '0);
      end else begin
        want = predicted_results.pop_front();
        if (read_key !== want.read_key) report_mismatch("read_key", read_key, want.read_key);
        if (status !== want.status)
          report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
        if (entry_count !== want.count)
          report_mismatch("entry_count", KEY_W'(entry_count), KEY_W'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $realtime, predicted_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_request(logic [1:0] req, logic [KEY_W-1:0] k, logic [ADDR_W-1:0] p);
    request_t r;
    r.req = req;
    r.key = k;
    r.pos = p;
    queued_requests.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom_range(0, 7));
      4: return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_req(req_mix_t mix);
    int roll;
    int ins_w;
    int rem_w;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_w = 60; rem_w = 15; end
      MIX_DRAIN: begin ins_w = 20; rem_w = 55; end
      default:   begin ins_w = 35; rem_w = 30; end
    endcase
    if (roll < 5) return REQ_UNUSED;
    if (roll < 5 + ins_w) return REQ_INSERT;
    if (roll < 5 + ins_w + rem_w) return REQ_REMOVE;
    return REQ_LOOKUP;
  endfunction

  // Waits until every queued request has been taken and every result seen.
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_requests.size() != 0 || holding || predicted_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(int value);
    cfg_valid <= 1'b1;
    capacity <= CAP_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    table_cap = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int phase_caps[PHASES];
    req_mix_t mix;
    int n;
    phase_caps = '{16, 4, 31, 1, 0, 16, 9, 2, 16, 13, 5, 16};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, duplicates, extreme keys and out-of-range positions.
    push_request(REQ_LOOKUP, '0, '0);
    push_request(REQ_REMOVE, '0, '0);
    push_request(REQ_UNUSED, '1, '1);
    push_request(REQ_INSERT, 32'd5, '0);
    push_request(REQ_INSERT, '0, '0);
    push_request(REQ_INSERT, '1, '1);
    push_request(REQ_INSERT, 32'd5, '0);
    push_request(REQ_LOOKUP, '0, 4'd0);
    push_request(REQ_LOOKUP, '0, 4'd1);
    push_request(REQ_LOOKUP, '0, 4'd2);
    push_request(REQ_LOOKUP, '0, 4'd3);
    push_request(REQ_LOOKUP, '0, 4'd15);
    push_request(REQ_REMOVE, '0, 4'd1);
    push_request(REQ_LOOKUP, '0, 4'd1);
    push_request(REQ_REMOVE, '0, 4'd15);
    wait_idle();

    // Capacity lowered below the count: entries stay, inserts report full.
    write_capacity(2);
    push_request(REQ_INSERT, 32'd9, '0);
    push_request(REQ_LOOKUP, '0, 4'd2);
    push_request(REQ_REMOVE, '0, 4'd0);
    push_request(REQ_INSERT, 32'd9, '0);
    push_request(REQ_REMOVE, '0, 4'd0);
    push_request(REQ_INSERT, 32'd7, '0);
    wait_idle();
    write_capacity(0);
    push_request(REQ_INSERT, 32'd3, '0);
    push_request(REQ_UNUSED, '0, '0);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      case (ph % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_EVEN;
        default: mix = MIX_DRAIN;
      endcase
      quiet = (ph == PHASES - 1);
      for (n = 0; n < 150; n++)
        push_request(pick_req(mix), pick_key(),
                     $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 15))
                                          : ADDR_W'($urandom_range(0, 3)));
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never seen", KEY_W'(predicted_results.size()), '0);
    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/sat_pkg.sv
design/sat_store.sv
design/sat_ctrl.sv
design/sorted_array_table_top.sv
test/tb_top.sv
